FILE: hw/rtl/i2cm_pkg.sv
// shared types and constants for the i2c master bit sequencer
// used by the sequencer core, the top level and the testbench
// no dependencies

package i2cm_pkg;

    // default width of the phase timer
    localparam int unsigned TICK_WIDTH_DEF = 16;

    // command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_STOP  = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd3;

    // configuration reset values
    localparam logic [15:0] QUARTER_RST = 16'd133;
    localparam logic [15:0] HALF_RST    = 16'd285;

    // configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // one input beat
    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] target_address;
        logic       read_not_write;
        logic [7:0] data_byte;
        logic       last_read;
        logic       scl_in;
        logic       sda_in;
    } t_item;

    // one result beat
    typedef struct packed {
        logic       scl_low;
        logic       scl_push_high;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] received_byte;
        logic       ack_seen;
        logic       bus_error;
    } t_res;

endpackage

FILE: hw/rtl/i2cm_cmd_if.sv
// input channel of the i2c master bit sequencer: valid, ready and one tick item
// no package dependency

interface i2cm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [7:0] data_byte;
    logic       last_read;
    logic       scl_in;
    logic       sda_in;

    modport source (
        output valid, cmd, target_address, read_not_write, data_byte, last_read,
               scl_in, sda_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, target_address, read_not_write, data_byte, last_read,
               scl_in, sda_in,
        output ready
    );
endinterface

FILE: hw/rtl/i2cm_res_if.sv
// result channel of the i2c master bit sequencer: valid, ready and line/status fields
// no package dependency

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_low;
    logic       scl_push_high;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] received_byte;
    logic       ack_seen;
    logic       bus_error;

    modport source (
        output valid, scl_low, scl_push_high, sda_low, busy_res, done_res,
               received_byte, ack_seen, bus_error,
        input  ready
    );
    modport sink (
        input  valid, scl_low, scl_push_high, sda_low, busy_res, done_res,
               received_byte, ack_seen, bus_error,
        output ready
    );
endinterface

FILE: hw/rtl/i2c_master_bit_sequencer.sv
// i2c master bit sequencer top level: channel handshake and result register
// depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2cm_core
//
// Each input beat on i_cmd is one timer tick. In idle a tick may carry a command
// (start plus address, write byte, read byte, stop); otherwise it just advances
// the running command. Every accepted beat yields exactly one result beat on
// o_res with the SCL/SDA drive levels after that tick, busy, a done pulse, the
// last read byte, the ack flag and the error flag.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data: 0 quarter period,
// 1 half period, 2 open drain, 3 bus enable; write only while the block is idle.
// Latency: the result of a beat is valid in the cycle after it is accepted.
// Throughput: one beat per cycle while results are taken; the next phase is combinational.
// The one-entry result register lets a new beat in whenever the held result is
// being taken in the same cycle; while the receiver stalls, i_cmd.ready is low.
// Reset (synchronous, active low) releases both lines, clears the sequencer state and
// the result valid flag, loads the period registers with 133 and 285 ticks and leaves the bus disabled.

module i2c_master_bit_sequencer #(
    parameter int unsigned TICK_WIDTH = i2cm_pkg::TICK_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    i2cm_cmd_if.sink                            i_cmd,
    i2cm_res_if.source                          o_res
);

    i2cm_pkg::t_cfg_wr cfg;
    i2cm_pkg::t_item   item;
    i2cm_pkg::t_res    res;
    i2cm_pkg::t_res    r_res;
    logic              r_out_valid;
    logic              step;

    // beat accepted when the result register is empty or being drained
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign step        = i_cmd.valid && i_cmd.ready;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign item.cmd            = i_cmd.cmd;
    assign item.target_address = i_cmd.target_address;
    assign item.read_not_write = i_cmd.read_not_write;
    assign item.data_byte      = i_cmd.data_byte;
    assign item.last_read      = i_cmd.last_read;
    assign item.scl_in         = i_cmd.scl_in;
    assign item.sda_in         = i_cmd.sda_in;

    i2cm_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (step),
        .i_item  (item),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.scl_low       = r_res.scl_low;
    assign o_res.scl_push_high = r_res.scl_push_high;
    assign o_res.sda_low       = r_res.sda_low;
    assign o_res.busy_res      = r_res.busy_res;
    assign o_res.done_res      = r_res.done_res;
    assign o_res.received_byte = r_res.received_byte;
    assign o_res.ack_seen      = r_res.ack_seen;
    assign o_res.bus_error     = r_res.bus_error;

endmodule

FILE: hw/rtl/i2cm_core.sv
// i2c master sequencer core: config registers, phase machine and line drivers
// depends on i2cm_pkg; advances one tick per i_step

module i2cm_core #(
    parameter int unsigned TICK_WIDTH = i2cm_pkg::TICK_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2cm_pkg::t_cfg_wr i_cfg,
    input  logic             i_step,
    input  i2cm_pkg::t_item  i_item,
    output i2cm_pkg::t_res   o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RS_SDA, PH_RS_RISE, PH_RS_HIGH, PH_ST_SDA, PH_ST_SCL,
        PH_B_SETUP, PH_B_RISE, PH_B_HIGH, PH_B_LOW,
        PH_SP_SDA, PH_SP_RISE, PH_SP_HIGH, PH_SP_END
    } t_phase;

    localparam int unsigned SAT_W = 33;

    // period register to timer load, clamped to one and to the timer width
    function automatic logic [TICK_WIDTH-1:0] load_count(input logic [15:0] reg_val);
        logic [SAT_W-1:0] v;
        logic [SAT_W-1:0] maxv;
        v    = SAT_W'(reg_val);
        maxv = (SAT_W'(1) << TICK_WIDTH) - SAT_W'(1);
        if (v > maxv) v = maxv;
        if (v == '0) v = SAT_W'(1);
        return v[TICK_WIDTH-1:0];
    endfunction

    // configuration
    logic [15:0] r_quarter, r_half;
    logic        r_od, r_en;

    // sequencer state
    t_phase                r_phase, n_phase;
    logic [TICK_WIDTH-1:0] r_tick, n_tick;
    logic [3:0]            r_bit, n_bit;
    logic [7:0]            r_shift, n_shift;
    logic                  r_owned, n_owned;
    logic                  r_ack, n_ack;
    logic [2:0]            r_pend, n_pend;
    logic                  r_nack, n_nack;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic [7:0]            r_rx, n_rx;
    logic                  r_errp, n_errp;

    logic   done, err, go, bdl;
    t_phase tgt, eff;
    logic [3:0] bit_inc;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_owned = r_owned;
        n_ack   = r_ack;
        n_pend  = r_pend;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_errp  = r_errp;
        done    = 1'b0;
        err     = 1'b0;
        go      = 1'b0;
        tgt     = PH_IDLE;
        eff     = PH_IDLE;
        bdl     = 1'b0;
        bit_inc = r_bit + 4'd1;

        // step: command decode, rise wait, countdown or phase advance
        if (r_phase == PH_IDLE) begin
            if (i_item.cmd == i2cm_pkg::CMD_START || i_item.cmd == i2cm_pkg::CMD_WRITE ||
                i_item.cmd == i2cm_pkg::CMD_READ || i_item.cmd == i2cm_pkg::CMD_STOP) begin
                if (!r_en || ((i_item.cmd == i2cm_pkg::CMD_WRITE ||
                               i_item.cmd == i2cm_pkg::CMD_READ) && !r_owned)) begin
                    done = 1'b1;
                    err  = 1'b1;
                end else begin
                    n_pend = i_item.cmd;
                    n_errp = 1'b0;
                    n_bit  = '0;
                    go     = 1'b1;
                    case (i_item.cmd)
                        i2cm_pkg::CMD_START: begin
                            n_shift = {i_item.target_address, i_item.read_not_write};
                            tgt     = r_owned ? PH_RS_SDA : PH_ST_SDA;
                        end
                        i2cm_pkg::CMD_WRITE: begin
                            n_shift = i_item.data_byte;
                            tgt     = PH_B_SETUP;
                        end
                        i2cm_pkg::CMD_READ: begin
                            n_shift = '0;
                            n_nack  = i_item.last_read;
                            tgt     = PH_B_SETUP;
                        end
                        default: begin
                            tgt = PH_SP_SDA;
                        end
                    endcase
                end
            end
        end else if (r_phase == PH_RS_RISE || r_phase == PH_B_RISE ||
                     r_phase == PH_SP_RISE) begin
            if (i_item.scl_in) begin
                go = 1'b1;
                case (r_phase)
                    PH_RS_RISE: tgt = PH_RS_HIGH;
                    PH_B_RISE:  tgt = PH_B_HIGH;
                    default:    tgt = PH_SP_HIGH;
                endcase
            end
        end else if (r_tick > TICK_WIDTH'(1)) begin
            n_tick = r_tick - TICK_WIDTH'(1);
        end else begin
            case (r_phase)
                PH_RS_SDA:  begin go = 1'b1; tgt = PH_RS_RISE; end
                PH_RS_HIGH: begin go = 1'b1; tgt = PH_ST_SDA; end
                PH_ST_SDA:  begin go = 1'b1; tgt = PH_ST_SCL; end
                PH_ST_SCL:  begin n_bit = '0; go = 1'b1; tgt = PH_B_SETUP; end
                PH_B_SETUP: begin go = 1'b1; tgt = PH_B_RISE; end
                PH_B_HIGH: begin
                    if (r_pend == i2cm_pkg::CMD_READ) begin
                        if (r_bit < 4'd8) n_shift = {r_shift[6:0], i_item.sda_in};
                    end else if (r_bit >= 4'd8) begin
                        n_ack = !i_item.sda_in;
                    end
                    go  = 1'b1;
                    tgt = PH_B_LOW;
                end
                PH_B_LOW: begin
                    if (bit_inc <= 4'd8) begin
                        n_bit = bit_inc;
                        go    = 1'b1;
                        tgt   = PH_B_SETUP;
                    end else begin
                        n_bit = '0;
                        if (r_pend == i2cm_pkg::CMD_READ) begin
                            n_rx    = r_shift;
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                            done    = 1'b1;
                        end else if (r_ack) begin
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                            done    = 1'b1;
                        end else begin
                            n_errp = 1'b1;
                            go     = 1'b1;
                            tgt    = PH_SP_SDA;
                        end
                    end
                end
                PH_SP_SDA:  begin go = 1'b1; tgt = PH_SP_RISE; end
                PH_SP_HIGH: begin go = 1'b1; tgt = PH_SP_END; end
                PH_SP_END: begin
                    n_owned = 1'b0;
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    done    = 1'b1;
                    err     = r_errp;
                    n_errp  = 1'b0;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    done    = 1'b1;
                end
            endcase
        end

        // data bit level for the next setup phase, from updated bit and shift state
        if (n_pend == i2cm_pkg::CMD_READ) begin
            bdl = (n_bit >= 4'd8) ? !n_nack : 1'b0;
        end else if (n_bit >= 4'd8) begin
            bdl = 1'b0;
        end else begin
            bdl = !n_shift[~n_bit[2:0]];
        end

        // phase entry: line changes and timer load; push-pull skips the rise wait
        if (go) begin
            eff = tgt;
            if (tgt == PH_RS_RISE || tgt == PH_B_RISE || tgt == PH_SP_RISE) begin
                n_scl = 1'b0;
                if (!r_od) begin
                    case (tgt)
                        PH_RS_RISE: eff = PH_RS_HIGH;
                        PH_B_RISE:  eff = PH_B_HIGH;
                        default:    eff = PH_SP_HIGH;
                    endcase
                end
            end
            n_phase = eff;
            case (eff)
                PH_RS_SDA:  begin n_sda = 1'b0; n_tick = load_count(r_quarter); end
                PH_ST_SDA: begin
                    n_sda   = 1'b1;
                    n_owned = 1'b1;
                    n_tick  = load_count(r_quarter);
                end
                PH_ST_SCL:  begin n_scl = 1'b1; n_tick = load_count(r_quarter); end
                PH_B_SETUP: begin n_sda = bdl; n_tick = load_count(r_quarter); end
                PH_B_LOW:   begin n_scl = 1'b1; n_tick = load_count(r_quarter); end
                PH_SP_SDA:  begin n_sda = 1'b1; n_tick = load_count(r_quarter); end
                PH_SP_END:  begin n_sda = 1'b0; n_tick = load_count(r_half); end
                PH_RS_HIGH: n_tick = load_count(r_quarter);
                PH_B_HIGH, PH_SP_HIGH: n_tick = load_count(r_half);
                PH_RS_RISE, PH_B_RISE, PH_SP_RISE: n_tick = '0;
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end
    end

    // result of this tick
    always_comb begin
        o_res.scl_low       = n_scl;
        o_res.scl_push_high = !n_scl && !r_od;
        o_res.sda_low       = n_sda;
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.done_res      = done;
        o_res.received_byte = n_rx;
        o_res.ack_seen      = n_ack;
        o_res.bus_error     = err;
    end

    // configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter <= i2cm_pkg::QUARTER_RST;
            r_half    <= i2cm_pkg::HALF_RST;
            r_od      <= 1'b0;
            r_en      <= 1'b0;
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_owned   <= 1'b0;
            r_ack     <= 1'b0;
            r_pend    <= i2cm_pkg::CMD_TICK;
            r_nack    <= 1'b0;
            r_scl     <= 1'b0;
            r_sda     <= 1'b0;
            r_rx      <= '0;
            r_errp    <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    i2cm_pkg::CFG_QUARTER: r_quarter <= i_cfg.data;
                    i2cm_pkg::CFG_HALF:    r_half    <= i_cfg.data;
                    i2cm_pkg::CFG_OD:      r_od      <= i_cfg.data[0];
                    i2cm_pkg::CFG_ENABLE:  r_en      <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_step) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_owned <= n_owned;
                r_ack   <= n_ack;
                r_pend  <= n_pend;
                r_nack  <= n_nack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_rx    <= n_rx;
                r_errp  <= n_errp;
            end
        end
    end

    // checks
    a_err_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        err |-> done)
        else $error("bus error without done");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit index past the ack bit");
    a_bits_need_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_B_SETUP || r_phase == PH_B_HIGH || r_phase == PH_B_LOW) |-> r_owned)
        else $error("data bit outside an open transfer");
    a_idle_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == '0))
        else $error("timer running while idle");
    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_tick)))
        else $error("state moved without a beat");

endmodule

FILE: dv/tb_i2c_master_bit_sequencer.sv
// self-checking testbench for the i2c master bit sequencer: tick-by-tick line prediction
// drives i2cm_cmd_if beats and checks every i2cm_res_if beat against the predicted line state
// depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2c_master_bit_sequencer

module tb_i2c_master_bit_sequencer;

    // phases of the predicted bus sequencer
    typedef enum logic [4:0] {
        S_IDLE, S_RSTART_SDA, S_RSTART_RISE, S_RSTART_HIGH, S_START_SDA, S_START_SCL,
        S_BIT_SETUP, S_BIT_RISE, S_BIT_HIGH, S_BIT_LOW,
        S_STOP_SDA, S_STOP_RISE, S_STOP_HIGH, S_STOP_END
    } t_line_phase;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data;

    i2cm_cmd_if cmd_if ();
    i2cm_res_if res_if ();

    i2c_master_bit_sequencer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    always #5 clk = ~clk;

    // predicted configuration
    logic [15:0] c_quarter, c_half;
    logic        c_od, c_en;

    // predicted sequencer state
    t_line_phase m_phase;
    int unsigned m_ticks;
    logic [3:0]  m_bit;
    logic [7:0]  m_shift, m_rx;
    logic [2:0]  m_cmd;
    logic        m_owned, m_ack, m_nack_last, m_scl_low, m_sda_low;
    logic        m_err_pend, m_done, m_err;

    // expected line states, oldest first
    i2cm_pkg::t_res exp_line_states[$];
    int          mismatch_count = 0;
    int          beats_sent = 0;

    // stimulus knobs, all in percent
    int          in_idle_pct = 0;
    int          res_stall_pct = 0;
    int          stretch_pct = 0;
    int          nack_pct = 0;

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] period_count(logic [15:0] reg_val);
        return (reg_val == 16'd0) ? 16'd1 : reg_val;
    endfunction

    function automatic logic data_bit_low();
        if (m_cmd == i2cm_pkg::CMD_READ)
            return (m_bit >= 4'd8) ? !m_nack_last : 1'b0;
        if (m_bit >= 4'd8)
            return 1'b0;
        return !m_shift[3'd7 - m_bit[2:0]];
    endfunction

    function automatic logic is_rise(t_line_phase ph);
        return ph == S_RSTART_RISE || ph == S_BIT_RISE || ph == S_STOP_RISE;
    endfunction

    function automatic t_line_phase after_rise(t_line_phase ph);
        case (ph)
            S_RSTART_RISE: return S_RSTART_HIGH;
            S_BIT_RISE:    return S_BIT_HIGH;
            default:       return S_STOP_HIGH;
        endcase
    endfunction

    // enter a phase: line change now, count loaded from the period registers
    function automatic void load_phase(t_line_phase ph);
        m_phase = ph;
        case (ph)
            S_RSTART_SDA: begin
                m_sda_low = 1'b0;
                m_ticks   = period_count(c_quarter);
            end
            S_START_SDA: begin
                m_sda_low = 1'b1;
                m_owned   = 1'b1;
                m_ticks   = period_count(c_quarter);
            end
            S_START_SCL, S_BIT_LOW: begin
                m_scl_low = 1'b1;
                m_ticks   = period_count(c_quarter);
            end
            S_BIT_SETUP: begin
                m_sda_low = data_bit_low();
                m_ticks   = period_count(c_quarter);
            end
            S_STOP_SDA: begin
                m_sda_low = 1'b1;
                m_ticks   = period_count(c_quarter);
            end
            S_STOP_END: begin
                m_sda_low = 1'b0;
                m_ticks   = period_count(c_half);
            end
            S_RSTART_HIGH: m_ticks = period_count(c_quarter);
            S_BIT_HIGH, S_STOP_HIGH: m_ticks = period_count(c_half);
            S_RSTART_RISE, S_BIT_RISE, S_STOP_RISE: begin
                m_scl_low = 1'b0;
                m_ticks   = 0;
                // push-pull: scl is known high, skip the wait
                if (!c_od)
                    load_phase(after_rise(ph));
            end
            default: begin
                m_phase = S_IDLE;
                m_ticks = 0;
            end
        endcase
    endfunction

    function automatic void end_command(logic err);
        m_phase = S_IDLE;
        m_ticks = 0;
        m_done  = 1'b1;
        m_err   = err;
    endfunction

    // count expired: move to the next phase
    function automatic void next_phase(logic sda);
        case (m_phase)
            S_RSTART_SDA:  load_phase(S_RSTART_RISE);
            S_RSTART_HIGH: load_phase(S_START_SDA);
            S_START_SDA:   load_phase(S_START_SCL);
            S_START_SCL: begin
                m_bit = 4'd0;
                load_phase(S_BIT_SETUP);
            end
            S_BIT_SETUP:   load_phase(S_BIT_RISE);
            S_BIT_HIGH: begin
                if (m_cmd == i2cm_pkg::CMD_READ) begin
                    if (m_bit < 4'd8)
                        m_shift = {m_shift[6:0], sda};
                end else if (m_bit >= 4'd8) begin
                    m_ack = !sda;
                end
                load_phase(S_BIT_LOW);
            end
            S_BIT_LOW: begin
                m_bit = m_bit + 4'd1;
                if (m_bit <= 4'd8) begin
                    load_phase(S_BIT_SETUP);
                end else begin
                    m_bit = 4'd0;
                    if (m_cmd == i2cm_pkg::CMD_READ) begin
                        m_rx = m_shift;
                        end_command(1'b0);
                    end else if (m_ack) begin
                        end_command(1'b0);
                    end else begin
                        // nack on address or write byte: stop on our own
                        m_err_pend = 1'b1;
                        load_phase(S_STOP_SDA);
                    end
                end
            end
            S_STOP_SDA:  load_phase(S_STOP_RISE);
            S_STOP_HIGH: load_phase(S_STOP_END);
            S_STOP_END: begin
                m_owned = 1'b0;
                end_command(m_err_pend);
                m_err_pend = 1'b0;
            end
            default: end_command(1'b0);
        endcase
    endfunction

    function automatic i2cm_pkg::t_res predict_line_state(i2cm_pkg::t_item it);
        i2cm_pkg::t_res r;
        m_done = 1'b0;
        m_err  = 1'b0;
        if (m_phase == S_IDLE) begin
            if (it.cmd >= i2cm_pkg::CMD_START && it.cmd <= i2cm_pkg::CMD_STOP) begin
                if (!c_en || ((it.cmd == i2cm_pkg::CMD_WRITE ||
                               it.cmd == i2cm_pkg::CMD_READ) && !m_owned)) begin
                    m_done = 1'b1;
                    m_err  = 1'b1;
                end else begin
                    m_cmd      = it.cmd;
                    m_err_pend = 1'b0;
                    m_bit      = 4'd0;
                    case (it.cmd)
                        i2cm_pkg::CMD_START: begin
                            m_shift = {it.target_address, it.read_not_write};
                            load_phase(m_owned ? S_RSTART_SDA : S_START_SDA);
                        end
                        i2cm_pkg::CMD_WRITE: begin
                            m_shift = it.data_byte;
                            load_phase(S_BIT_SETUP);
                        end
                        i2cm_pkg::CMD_READ: begin
                            m_shift     = 8'd0;
                            m_nack_last = it.last_read;
                            load_phase(S_BIT_SETUP);
                        end
                        default: load_phase(S_STOP_SDA);
                    endcase
                end
            end
        end else if (is_rise(m_phase)) begin
            if (it.scl_in)
                load_phase(after_rise(m_phase));
        end else if (m_ticks > 1) begin
            m_ticks--;
        end else begin
            next_phase(it.sda_in);
        end
        r.scl_low       = m_scl_low;
        r.scl_push_high = !m_scl_low && !c_od;
        r.sda_low       = m_sda_low;
        r.busy_res      = (m_phase != S_IDLE);
        r.done_res      = m_done;
        r.received_byte = m_rx;
        r.ack_seen      = m_ack;
        r.bus_error     = m_err;
        return r;
    endfunction

    function automatic void reset_line_model();
        c_quarter   = i2cm_pkg::QUARTER_RST;
        c_half      = i2cm_pkg::HALF_RST;
        c_od        = 1'b0;
        c_en        = 1'b0;
        m_phase     = S_IDLE;
        m_ticks     = 0;
        m_bit       = 4'd0;
        m_shift     = 8'd0;
        m_rx        = 8'd0;
        m_cmd       = i2cm_pkg::CMD_TICK;
        m_owned     = 1'b0;
        m_ack       = 1'b0;
        m_nack_last = 1'b0;
        m_scl_low   = 1'b0;
        m_sda_low   = 1'b0;
        m_err_pend  = 1'b0;
        m_done      = 1'b0;
        m_err       = 1'b0;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic check_line_state(i2cm_pkg::t_res got);
        i2cm_pkg::t_res want;
        string          diff;
        if (exp_line_states.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result beat %h", got);
        end else begin
            want = exp_line_states.pop_front();
            diff = "";
            if (got.scl_low !== want.scl_low)             diff = {diff, " scl_low"};
            if (got.scl_push_high !== want.scl_push_high) diff = {diff, " scl_push_high"};
            if (got.sda_low !== want.sda_low)             diff = {diff, " sda_low"};
            if (got.busy_res !== want.busy_res)           diff = {diff, " busy_res"};
            if (got.done_res !== want.done_res)           diff = {diff, " done_res"};
            if (got.received_byte !== want.received_byte) diff = {diff, " received_byte"};
            if (got.ack_seen !== want.ack_seen)           diff = {diff, " ack_seen"};
            if (got.bus_error !== want.bus_error)         diff = {diff, " bus_error"};
            if (diff != "") begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result mismatch:%s expected %h got %h", diff, want, got);
            end
        end
    endtask

    // monitor: check result beats, track config writes, predict each accepted beat
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_if.valid && res_if.ready)
                check_line_state('{res_if.scl_low, res_if.scl_push_high, res_if.sda_low,
                                   res_if.busy_res, res_if.done_res, res_if.received_byte,
                                   res_if.ack_seen, res_if.bus_error});
            if (cfg_we) begin
                case (cfg_idx)
                    i2cm_pkg::CFG_QUARTER: c_quarter = cfg_data;
                    i2cm_pkg::CFG_HALF:    c_half    = cfg_data;
                    i2cm_pkg::CFG_OD:      c_od      = cfg_data[0];
                    i2cm_pkg::CFG_ENABLE:  c_en      = cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd_if.valid && cmd_if.ready)
                exp_line_states.push_back(predict_line_state('{cmd_if.cmd,
                    cmd_if.target_address, cmd_if.read_not_write, cmd_if.data_byte,
                    cmd_if.last_read, cmd_if.scl_in, cmd_if.sda_in}));
        end
    end

    // ---------------------------------------------------------------- drivers

    // result-side stalls, mostly short with a few long ones
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < res_stall_pct) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= in_idle_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // one tick beat shaped like a target on the bus: stretches scl, acks bytes
    function automatic i2cm_pkg::t_item line_tick_item();
        i2cm_pkg::t_item it;
        if (m_phase != S_IDLE)
            it.cmd = 3'($urandom_range(0, 7));
        else if ($urandom_range(0, 3) == 0)
            it.cmd = i2cm_pkg::CMD_STOP + 3'($urandom_range(1, 3));
        else
            it.cmd = i2cm_pkg::CMD_TICK;
        it.target_address = 7'($urandom_range(0, 127));
        it.read_not_write = 1'($urandom_range(0, 1));
        it.data_byte      = 8'($urandom_range(0, 255));
        it.last_read      = 1'($urandom_range(0, 1));
        if (is_rise(m_phase))
            it.scl_in = ($urandom_range(0, 99) >= stretch_pct);
        else
            it.scl_in = 1'($urandom_range(0, 1));
        if (m_phase == S_BIT_HIGH && m_cmd != i2cm_pkg::CMD_READ && m_bit >= 4'd8)
            it.sda_in = ($urandom_range(0, 99) < nack_pct);
        else
            it.sda_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // send one beat; entered and left just after a falling edge, valid left high
    task automatic send_beat(i2cm_pkg::t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.cmd            <= it.cmd;
        cmd_if.target_address <= it.target_address;
        cmd_if.read_not_write <= it.read_not_write;
        cmd_if.data_byte      <= it.data_byte;
        cmd_if.last_read      <= it.last_read;
        cmd_if.scl_in         <= it.scl_in;
        cmd_if.sda_in         <= it.sda_in;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    // issue a command in idle and tick until the sequencer is idle again
    task automatic run_command(logic [2:0] code, logic [6:0] addr, logic rnw,
                               logic [7:0] data, logic last);
        i2cm_pkg::t_item it;
        it                = line_tick_item();
        it.cmd            = code;
        it.target_address = addr;
        it.read_not_write = rnw;
        it.data_byte      = data;
        it.last_read      = last;
        send_beat(it);
        while (m_phase != S_IDLE) send_beat(line_tick_item());
    endtask

    // stop sending and wait for every expected beat
    task automatic settle_idle();
        cmd_if.valid <= 1'b0;
        while (exp_line_states.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [i2cm_pkg::CFG_IDX_W-1:0] idx,
                             logic [i2cm_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_timing(logic [15:0] quarter, logic [15:0] half, logic od);
        settle_idle();
        cfg_write(i2cm_pkg::CFG_QUARTER, quarter);
        cfg_write(i2cm_pkg::CFG_HALF, half);
        cfg_write(i2cm_pkg::CFG_OD, {15'd0, od});
    endtask

    // ---------------------------------------------------------------- tests

    // bus disabled after reset: every command refused
    task automatic test_refused_while_disabled();
        in_idle_pct   = 30;
        res_stall_pct = 20;
        run_command(i2cm_pkg::CMD_START, 7'h7F, 1'b1, 8'hFF, 1'b1);
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    endtask

    // one stop with the reset periods, push-pull
    task automatic test_reset_periods();
        settle_idle();
        cfg_write(i2cm_pkg::CFG_ENABLE, 16'd1);
        in_idle_pct   = 0;
        res_stall_pct = 0;
        nack_pct      = 0;
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    endtask

    // write and read with no open transfer, stop anyway, unused codes
    task automatic test_no_transfer();
        set_timing(16'd1, 16'd1, 1'b0);
        in_idle_pct   = 30;
        res_stall_pct = 20;
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_STOP + 3'd1, 7'h7F, 1'b1, 8'hFF, 1'b1);
        run_command(i2cm_pkg::CMD_STOP + 3'd2, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_STOP + 3'd3, 7'h55, 1'b1, 8'h5A, 1'b0);
    endtask

    // address and data extremes, nack auto-stop, reads, repeated start
    task automatic test_byte_transfers();
        nack_pct = 0;
        run_command(i2cm_pkg::CMD_START, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0);
        nack_pct = 100;
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0);
        run_command(i2cm_pkg::CMD_START, 7'h13, 1'b0, 8'h00, 1'b0);
        nack_pct = 0;
        run_command(i2cm_pkg::CMD_START, 7'h2A, 1'b1, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 7'h00, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1);
        run_command(i2cm_pkg::CMD_START, 7'h55, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'h3C, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    endtask

    // open-drain with the target holding scl low
    task automatic test_open_drain_stretch();
        set_timing(16'd2, 16'd3, 1'b1);
        stretch_pct = 60;
        run_command(i2cm_pkg::CMD_START, 7'h6B, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'h96, 1'b0);
        run_command(i2cm_pkg::CMD_START, 7'h6B, 1'b1, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_READ, 7'h00, 1'b0, 8'h00, 1'b1);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
        stretch_pct = 0;
    endtask

    // zero period registers count as one tick
    task automatic test_zero_periods();
        set_timing(16'd0, 16'd0, 1'b0);
        run_command(i2cm_pkg::CMD_START, 7'h41, 1'b0, 8'h00, 1'b0);
        run_command(i2cm_pkg::CMD_WRITE, 7'h00, 1'b0, 8'h81, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    endtask

    // long quarter or long half period against a one-tick other, one stop each
    task automatic test_period_extremes();
        in_idle_pct   = 0;
        res_stall_pct = 0;
        set_timing(16'd32, 16'd1, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
        set_timing(16'd1, 16'd32, 1'b0);
        run_command(i2cm_pkg::CMD_STOP, 7'h00, 1'b0, 8'h00, 1'b0);
    endtask

    function automatic logic [15:0] random_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'd1;
        if (r < 85) return 16'($urandom_range(2, 4));
        if (r < 95) return 16'($urandom_range(5, 8));
        return 16'd0;
    endfunction

    // random settings, mostly well-formed transfers with some noise
    task automatic test_random_traffic(int n_beats);
        int        stop_at, n_bytes;
        logic      rnw;
        logic [6:0] addr;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            set_timing(random_period(), random_period(), 1'($urandom_range(0, 1)));
            cfg_write(i2cm_pkg::CFG_ENABLE, ($urandom_range(0, 9) == 0) ? 16'd0 : 16'd1);
            in_idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            res_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            stretch_pct   = $urandom_range(0, 2) * 40;
            repeat ($urandom_range(2, 4)) begin
                nack_pct = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2) * 25;
                if ($urandom_range(0, 99) < 20) begin
                    // noise: commands in any order
                    repeat ($urandom_range(1, 3))
                        run_command(i2cm_pkg::CMD_START + 3'($urandom_range(0, 3)),
                                    7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    rnw     = 1'($urandom_range(0, 1));
                    addr    = 7'($urandom_range(0, 127));
                    n_bytes = $urandom_range(1, 4);
                    run_command(i2cm_pkg::CMD_START, addr, rnw,
                                8'($urandom_range(0, 255)), 1'b0);
                    for (int k = 0; k < n_bytes; k++) begin
                        if (rnw)
                            run_command(i2cm_pkg::CMD_READ, 7'($urandom_range(0, 127)),
                                        1'b0, 8'($urandom_range(0, 255)),
                                        k == n_bytes - 1);
                        else
                            run_command(i2cm_pkg::CMD_WRITE, 7'($urandom_range(0, 127)),
                                        1'b1, 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)));
                    end
                    // sometimes leave the bus open for a repeated start
                    if ($urandom_range(0, 99) < 85)
                        run_command(i2cm_pkg::CMD_STOP, addr, rnw,
                                    8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        reset_line_model();
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= i2cm_pkg::CFG_QUARTER;
        cfg_data              <= '0;
        cmd_if.valid          <= 1'b0;
        cmd_if.cmd            <= i2cm_pkg::CMD_TICK;
        cmd_if.target_address <= '0;
        cmd_if.read_not_write <= 1'b0;
        cmd_if.data_byte      <= '0;
        cmd_if.last_read      <= 1'b0;
        cmd_if.scl_in         <= 1'b1;
        cmd_if.sda_in         <= 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_refused_while_disabled();
        test_reset_periods();
        test_no_transfer();
        test_byte_transfers();
        test_open_drain_stretch();
        test_zero_periods();
        test_period_extremes();
        test_random_traffic(250);

        settle_idle();
        if (mismatch_count == 0)
            $display("** i2c_master_bit_sequencer: PASSED **");
        else
            $display("** i2c_master_bit_sequencer: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("** i2c_master_bit_sequencer: FAILED **");
        $finish;
    end

endmodule
